### sv/tpjq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjq_pkg
// Shared constants and types for the timed priority job queue.
// ----------------------------------------------------------------------------
package tpjq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned ID_W = 31;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned WAIT_W = 24;

  localparam logic [TIME_W:0] HORIZON_MS = 49'd9999000;
  localparam logic [WAIT_W-1:0] IDLE_RESET = 24'd5000;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_POLL = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage
`default_nettype wire

### sv/tpjq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjq_ctrl
// Sequencer: load the command, scan every slot, then commit the result.
// ----------------------------------------------------------------------------
module tpjq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tpjq_pkg::dp_sts_t sts_i,
  output tpjq_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### sv/tpjq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjq_datapath
// Job table, one-slot-per-cycle scan unit and registered result.
// ----------------------------------------------------------------------------
module tpjq_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tpjq_pkg::dp_cmd_t                  cmd_i,
  output tpjq_pkg::dp_sts_t                       sts_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tpjq_pkg::WAIT_W-1:0]        cfg_wdata_i,
  input  wire logic [2:0]                         opcode_i,
  input  wire logic [tpjq_pkg::TIME_W-1:0]        now_ms_i,
  input  wire logic signed [7:0]                  priority_req_i,
  input  wire logic [31:0]                        delay_ms_i,
  input  wire logic [tpjq_pkg::HANDLE_W-1:0]      job_handle_i,
  input  wire logic [tpjq_pkg::ID_W-1:0]          target_id_i,
  output logic                                    done_o,
  output logic [1:0]                              status_o,
  output logic [tpjq_pkg::ID_W-1:0]               out_id_o,
  output logic [tpjq_pkg::HANDLE_W-1:0]           out_handle_o,
  output logic [tpjq_pkg::WAIT_W-1:0]             wait_ms_o,
  output logic                                    is_queued_o,
  output logic [tpjq_pkg::CNT_W-1:0]              removed_count_o,
  output logic [tpjq_pkg::CNT_W-1:0]              pending_count_o
);

  localparam int unsigned N = tpjq_pkg::QUEUE_DEPTH;
  localparam int unsigned IW = tpjq_pkg::IDX_W;
  localparam int unsigned TW = tpjq_pkg::TIME_W;

  // Table storage.
  logic [N-1:0]                        valid_q, valid_d;
  logic signed [7:0]                   prio_q [N];
  logic [TW-1:0]                       start_q [N];
  logic [tpjq_pkg::ID_W-1:0]           id_q [N];
  logic [tpjq_pkg::HANDLE_W-1:0]       handle_q [N];
  logic [tpjq_pkg::ID_W-1:0]           next_id_q;
  logic [tpjq_pkg::CNT_W-1:0]          pending_q;
  logic [tpjq_pkg::WAIT_W-1:0]         idle_wait_q;

  // Latched command.
  logic [2:0]                          op_q;
  logic [TW-1:0]                       now_q;
  logic signed [7:0]                   new_prio_q;
  logic [TW-1:0]                       new_start_q;
  logic [tpjq_pkg::HANDLE_W-1:0]       new_handle_q;
  logic [tpjq_pkg::ID_W-1:0]           target_q;

  // Scan state.
  logic [IW-1:0]                       idx_q;
  logic                                best_v_q;
  logic [IW-1:0]                       best_idx_q;
  logic signed [7:0]                   best_prio_q;
  logic [TW-1:0]                       best_start_q;
  logic [tpjq_pkg::ID_W-1:0]           best_id_q;
  logic [tpjq_pkg::HANDLE_W-1:0]       best_handle_q;
  logic                                any_q;
  logic [TW-1:0]                       earliest_q;
  logic                                found_q;

  logic [TW:0]                         start_sum;
  logic [TW-1:0]                       start_calc;

  assign start_sum = {1'b0, now_ms_i} + {{(TW-31){1'b0}}, delay_ms_i};
  always_comb begin
    if (delay_ms_i == '0) start_calc = '0;
    else if (start_sum[TW]) start_calc = '1;
    else start_calc = start_sum[TW-1:0];
  end

  // Current slot under inspection.
  logic                                c_valid;
  logic signed [7:0]                   c_prio;
  logic [TW-1:0]                       c_start;
  logic [tpjq_pkg::ID_W-1:0]           c_id;
  logic                                c_before;
  logic                                c_cand;
  logic                                c_match;

  assign c_valid = valid_q[idx_q];
  assign c_prio = prio_q[idx_q];
  assign c_start = start_q[idx_q];
  assign c_id = id_q[idx_q];
  assign c_match = c_valid && (c_id == target_q);

  always_comb begin
    c_before = (c_prio < best_prio_q) ||
               ((c_prio == best_prio_q) &&
                ((c_start < best_start_q) ||
                 ((c_start == best_start_q) && (c_id < best_id_q))));
    case (op_q)
      tpjq_pkg::OP_POLL:   c_cand = c_valid && (c_start < now_q);
      tpjq_pkg::OP_CANCEL: c_cand = c_match;
      default:             c_cand = 1'b0;
    endcase
  end

  assign sts_o.last = (idx_q == IW'(N - 1));

  // Lowest free slot for an add.
  logic [IW-1:0] free_idx;
  logic          full;
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end
  assign full = &valid_q;

  logic [TW:0] horizon_end;
  assign horizon_end = {1'b0, now_q} + tpjq_pkg::HORIZON_MS;

  // Scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      now_q <= now_ms_i;
      new_prio_q <= priority_req_i;
      new_start_q <= start_calc;
      new_handle_q <= job_handle_i;
      target_q <= target_id_i;
      idx_q <= '0;
      best_v_q <= 1'b0;
      any_q <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IW'(1);
      if (c_cand && (!best_v_q || c_before)) begin
        best_v_q <= 1'b1;
        best_idx_q <= idx_q;
        best_prio_q <= c_prio;
        best_start_q <= c_start;
        best_id_q <= c_id;
        best_handle_q <= handle_q[idx_q];
      end
      if (c_valid && (!any_q || c_start < earliest_q)) begin
        earliest_q <= c_start;
        any_q <= 1'b1;
      end
      if (c_match) found_q <= 1'b1;
    end
  end

  // Table payload written by an add.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && op_q == tpjq_pkg::OP_ADD && !full) begin
      prio_q[free_idx] <= new_prio_q;
      start_q[free_idx] <= new_start_q;
      id_q[free_idx] <= next_id_q;
      handle_q[free_idx] <= new_handle_q;
    end
  end

  // Commit decode.
  logic [1:0]                      r_status;
  logic [tpjq_pkg::ID_W-1:0]       r_id, next_id_d;
  logic [tpjq_pkg::HANDLE_W-1:0]   r_handle;
  logic [tpjq_pkg::WAIT_W-1:0]     r_wait;
  logic                            r_queued;
  logic [tpjq_pkg::CNT_W-1:0]      r_removed, pending_d;

  always_comb begin
    valid_d = valid_q;
    next_id_d = next_id_q;
    pending_d = pending_q;
    r_status = tpjq_pkg::ST_OK;
    r_id = '0;
    r_handle = '0;
    r_wait = '0;
    r_queued = 1'b0;
    r_removed = '0;
    case (op_q)
      tpjq_pkg::OP_ADD: begin
        if (full) begin
          r_status = tpjq_pkg::ST_FULL;
        end else begin
          valid_d[free_idx] = 1'b1;
          r_id = next_id_q;
          next_id_d = next_id_q + tpjq_pkg::ID_W'(1);
          pending_d = pending_q + tpjq_pkg::CNT_W'(1);
        end
      end
      tpjq_pkg::OP_POLL: begin
        if (best_v_q) begin
          valid_d[best_idx_q] = 1'b0;
          r_id = best_id_q;
          r_handle = best_handle_q;
          pending_d = pending_q - tpjq_pkg::CNT_W'(1);
        end else begin
          r_status = tpjq_pkg::ST_NOT_READY;
          if (any_q && ({1'b0, earliest_q} < horizon_end)) begin
            r_wait = tpjq_pkg::WAIT_W'(earliest_q - now_q);
          end else begin
            r_wait = idle_wait_q;
          end
        end
      end
      tpjq_pkg::OP_CANCEL: begin
        if (best_v_q) begin
          valid_d[best_idx_q] = 1'b0;
          pending_d = pending_q - tpjq_pkg::CNT_W'(1);
        end else begin
          r_status = tpjq_pkg::ST_NOT_FOUND;
        end
      end
      tpjq_pkg::OP_QUERY: r_queued = found_q;
      tpjq_pkg::OP_CLEAR: begin
        valid_d = '0;
        r_removed = pending_q;
        pending_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      next_id_q <= '0;
      pending_q <= '0;
      idle_wait_q <= tpjq_pkg::IDLE_RESET;
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.commit;
      if (cfg_we_i) idle_wait_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        next_id_q <= next_id_d;
        pending_q <= pending_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o <= r_status;
      out_id_o <= r_id;
      out_handle_o <= r_handle;
      wait_ms_o <= r_wait;
      is_queued_o <= r_queued;
      removed_count_o <= r_removed;
      pending_count_o <= pending_d;
    end
  end

endmodule
`default_nettype wire

### sv/timed_priority_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_priority_job_queue
// Sixteen-slot job table ordered by priority, start time and id.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// command   in         start_i high, !busy_o  opcode, now, priority, delay,
//                                             handle, target id
// result    out        done_o, one cycle      status, id, handle, wait,
//                                             queued flag, counts
// config    in         cfg_we_i               idle_wait (24 bits)
//
// The edge that accepts a command also loads it. A scan of every table slot
// follows, one slot per cycle through the shared compare unit, and then the
// commit state; done_o rises at the edge that ends the commit state, which
// also registers the result word that the receiver takes with done_o.
// busy_o is high from the cycle after acceptance through the commit cycle; a
// new command may be accepted in the same cycle as the previous result word,
// so a new command is taken only after the previous one has been committed.
// Reset clears all valid marks, the id counter and the entry count at once;
// there is no clearing pass. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module timed_priority_job_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpjq_pkg::WAIT_W-1:0]   cfg_wdata_i,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic [tpjq_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic signed [7:0]             priority_req_i,
  input  wire logic [31:0]                   delay_ms_i,
  input  wire logic [tpjq_pkg::HANDLE_W-1:0] job_handle_i,
  input  wire logic [tpjq_pkg::ID_W-1:0]     target_id_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [tpjq_pkg::ID_W-1:0]          out_id_o,
  output logic [tpjq_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic [tpjq_pkg::WAIT_W-1:0]        wait_ms_o,
  output logic                               is_queued_o,
  output logic [tpjq_pkg::CNT_W-1:0]         removed_count_o,
  output logic [tpjq_pkg::CNT_W-1:0]         pending_count_o
);

  // The controller only sequences; all table state lives in the datapath.
  tpjq_pkg::dp_cmd_t cmd;
  tpjq_pkg::dp_sts_t sts;

  tpjq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  tpjq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .now_ms_i       (now_ms_i),
    .priority_req_i (priority_req_i),
    .delay_ms_i     (delay_ms_i),
    .job_handle_i   (job_handle_i),
    .target_id_i    (target_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_handle_o   (out_handle_o),
    .wait_ms_o      (wait_ms_o),
    .is_queued_o    (is_queued_o),
    .removed_count_o(removed_count_o),
    .pending_count_o(pending_count_o)
  );

endmodule
`default_nettype wire

### sv/tpjq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpjq_checker
// Port-level checks for the timed priority job queue.
// ----------------------------------------------------------------------------
module tpjq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic                         done_o,
  input wire logic [1:0]                   status_o,
  input wire logic [tpjq_pkg::CNT_W-1:0]   pending_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result word while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == tpjq_pkg::ST_FULL) |->
      (pending_count_o == tpjq_pkg::CNT_W'(tpjq_pkg::QUEUE_DEPTH)))
    else $error("full reported with free slots");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pending_count_o <= tpjq_pkg::CNT_W'(tpjq_pkg::QUEUE_DEPTH)))
    else $error("entry count beyond table depth");

endmodule

bind timed_priority_job_queue tpjq_checker u_tpjq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .status_o       (status_o),
  .pending_count_o(pending_count_o)
);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed priority job queue.
// ----------------------------------------------------------------------------
// Commands are queued by the stimulus process and issued by a clocked driver.
// When the block accepts a command, a behavioral copy of the job table is
// updated and the result word it must return is queued. A clocked monitor
// compares every result word with the oldest queued one. The idle_wait
// register is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import tpjq_pkg::*;

  // One command word plus the idle cycles the driver inserts before it.
  typedef struct {
    logic [2:0]          op;
    logic [TIME_W-1:0]   now;
    logic signed [7:0]   prio;
    logic [31:0]         delay;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     target;
    int unsigned         gap;
  } cmd_word_t;

  // One result word as the block reports it.
  typedef struct {
    logic [1:0]          status;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [WAIT_W-1:0]   wait_ms;
    logic                queued;
    logic [CNT_W-1:0]    removed;
    logic [CNT_W-1:0]    pending;
  } result_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WAIT_W-1:0]   cfg_wdata_i = '0;
  logic [2:0]          opcode_i = '0;
  logic [TIME_W-1:0]   now_ms_i = '0;
  logic signed [7:0]   priority_req_i = '0;
  logic [31:0]         delay_ms_i = '0;
  logic [HANDLE_W-1:0] job_handle_i = '0;
  logic [ID_W-1:0]     target_id_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [1:0]          status_o;
  logic [ID_W-1:0]     out_id_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic [WAIT_W-1:0]   wait_ms_o;
  logic                is_queued_o;
  logic [CNT_W-1:0]    removed_count_o;
  logic [CNT_W-1:0]    pending_count_o;

  timed_priority_job_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .now_ms_i        (now_ms_i),
    .priority_req_i  (priority_req_i),
    .delay_ms_i      (delay_ms_i),
    .job_handle_i    (job_handle_i),
    .target_id_i     (target_id_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_id_o        (out_id_o),
    .out_handle_o    (out_handle_o),
    .wait_ms_o       (wait_ms_o),
    .is_queued_o     (is_queued_o),
    .removed_count_o (removed_count_o),
    .pending_count_o (pending_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Behavioral copy of the job table and the idle_wait register.
  logic                slot_used [QUEUE_DEPTH];
  logic signed [7:0]   slot_prio [QUEUE_DEPTH];
  logic [TIME_W-1:0]   slot_start [QUEUE_DEPTH];
  logic [ID_W-1:0]     slot_id [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] slot_handle [QUEUE_DEPTH];
  logic [ID_W-1:0]     id_counter = '0;
  logic [CNT_W-1:0]    table_fill = '0;
  logic [WAIT_W-1:0]   idle_wait_reg = IDLE_RESET;

  cmd_word_t    pending_cmds [$];
  result_word_t expected_words [$];
  int unsigned  error_count = 0;
  int unsigned  words_checked = 0;
  int unsigned  polls_dispatched = 0;
  int unsigned  polls_waiting = 0;
  int unsigned  adds_rejected = 0;

  initial begin
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  // True when slot a comes before slot b in dispatch order.
  function automatic bit runs_first(int a, int b);
    if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
    if (slot_start[a] != slot_start[b]) return slot_start[a] < slot_start[b];
    return slot_id[a] < slot_id[b];
  endfunction

  // Applies one accepted command to the table copy and queues the word the
  // block has to return for it.
  task automatic apply_job_command(input cmd_word_t c);
    result_word_t r;
    int pick;
    bit any;
    logic [TIME_W-1:0] earliest;
    logic [TIME_W:0] sum;
    r = '{default: '0};
    pick = -1;
    any = 1'b0;
    earliest = '0;
    case (c.op)
      OP_ADD: begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (!slot_used[i] && pick < 0) pick = i;
        if (pick < 0) begin
          r.status = ST_FULL;
          adds_rejected++;
        end else begin
          // Zero delay means ready at once; otherwise the sum saturates.
          sum = {1'b0, c.now} + c.delay;
          slot_used[pick] = 1'b1;
          slot_prio[pick] = c.prio;
          slot_start[pick] = (c.delay == 0) ? '0 : (sum[TIME_W] ? '1 : sum[TIME_W-1:0]);
          slot_id[pick] = id_counter;
          slot_handle[pick] = c.handle;
          r.id = id_counter;
          id_counter++;
          table_fill++;
        end
      end
      OP_POLL: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (slot_used[i]) begin
            if (slot_start[i] < c.now && (pick < 0 || runs_first(i, pick))) pick = i;
            if (!any || slot_start[i] < earliest) earliest = slot_start[i];
            any = 1'b1;
          end
        end
        if (pick >= 0) begin
          slot_used[pick] = 1'b0;
          r.id = slot_id[pick];
          r.handle = slot_handle[pick];
          table_fill--;
          polls_dispatched++;
        end else begin
          r.status = ST_NOT_READY;
          polls_waiting++;
          if (any && {1'b0, earliest} < {1'b0, c.now} + HORIZON_MS)
            r.wait_ms = WAIT_W'(earliest - c.now);
          else
            r.wait_ms = idle_wait_reg;
        end
      end
      OP_CANCEL: begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (slot_used[i] && slot_id[i] == c.target && (pick < 0 || runs_first(i, pick)))
            pick = i;
        if (pick >= 0) begin
          slot_used[pick] = 1'b0;
          table_fill--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (slot_used[i] && slot_id[i] == c.target) r.queued = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (slot_used[i]) begin
            slot_used[i] = 1'b0;
            r.removed++;
          end
        table_fill = '0;
      end
      default: ;
    endcase
    r.pending = table_fill;
    expected_words.push_back(r);
  endtask

  // Driver: holds the current word on the ports until the block takes it,
  // then counts down the idle gap of the next word before raising start_i.
  cmd_word_t   cur_cmd;
  bit          have_cmd = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        apply_job_command(cur_cmd);
        have_cmd = 1'b0;
      end
      if (!have_cmd && pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        have_cmd = 1'b1;
        gap_left = cur_cmd.gap;
      end
      if (have_cmd && gap_left == 0) begin
        start_i <= 1'b1;
        opcode_i <= cur_cmd.op;
        now_ms_i <= cur_cmd.now;
        priority_req_i <= cur_cmd.prio;
        delay_ms_i <= cur_cmd.delay;
        job_handle_i <= cur_cmd.handle;
        target_id_i <= cur_cmd.target;
      end else begin
        start_i <= 1'b0;
        if (have_cmd) gap_left--;
      end
    end
  end

  // Monitor: every result word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, status %0d id %0d", $time, status_o, out_id_o);
        error_count++;
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, status_o);
          error_count++;
        end
        if (out_id_o !== e.id) begin
          $display("%0t: out_id expected %0d got %0d", $time, e.id, out_id_o);
          error_count++;
        end
        if (out_handle_o !== e.handle) begin
          $display("%0t: out_handle expected %h got %h", $time, e.handle, out_handle_o);
          error_count++;
        end
        if (wait_ms_o !== e.wait_ms) begin
          $display("%0t: wait_ms expected %0d got %0d", $time, e.wait_ms, wait_ms_o);
          error_count++;
        end
        if (is_queued_o !== e.queued) begin
          $display("%0t: is_queued expected %0d got %0d", $time, e.queued, is_queued_o);
          error_count++;
        end
        if (removed_count_o !== e.removed) begin
          $display("%0t: removed_count expected %0d got %0d", $time, e.removed,
                   removed_count_o);
          error_count++;
        end
        if (pending_count_o !== e.pending) begin
          $display("%0t: pending_count expected %0d got %0d", $time, e.pending,
                   pending_count_o);
          error_count++;
        end
      end
    end
  end

  function automatic cmd_word_t job_cmd(logic [2:0] op, logic [TIME_W-1:0] now,
                                        logic signed [7:0] prio, logic [31:0] delay,
                                        logic [HANDLE_W-1:0] handle, logic [ID_W-1:0] target);
    cmd_word_t c;
    c.op = op;
    c.now = now;
    c.prio = prio;
    c.delay = delay;
    c.handle = handle;
    c.target = target;
    c.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    return c;
  endfunction

  // Random traffic: time mostly advances slowly so that jobs become ready
  // and polls land inside the horizon; ids mostly hit recently issued jobs.
  logic [TIME_W-1:0] clock_ms = 48'd100000;
  logic [ID_W-1:0]   ids_issued = '0;

  function automatic cmd_word_t random_cmd(bit no_gap);
    cmd_word_t c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, 400);
    c = job_cmd(OP_ADD, clock_ms, $signed(8'($urandom_range(0, 6) - 3)),
                $urandom_range(0, 3000), $urandom, ids_issued - $urandom_range(1, 20));
    if (roll < 40) begin
      c.op = OP_ADD;
      ids_issued++;
    end else if (roll < 72) c.op = OP_POLL;
    else if (roll < 84) c.op = OP_CANCEL;
    else if (roll < 94) c.op = OP_QUERY;
    else if (roll < 97) c.op = OP_CLEAR;
    else c.op = 3'($urandom_range(5, 7));
    // Occasional wide values so every field bit toggles.
    if ($urandom_range(0, 9) == 0) c.prio = $signed(8'($urandom));
    if ($urandom_range(0, 9) == 0) c.delay = $urandom;
    else if ($urandom_range(0, 9) == 0) c.delay = $urandom_range(9990000, 10010000);
    else if ($urandom_range(0, 9) == 0) c.delay = 0;
    if ($urandom_range(0, 19) == 0) c.now = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 9) == 0) c.target = 31'($urandom);
    if (no_gap) c.gap = 0;
    return c;
  endfunction

  task automatic drain_block();
    while (pending_cmds.size() != 0 || have_cmd || start_i || expected_words.size() != 0)
      @(posedge clk_i);
    // Every command returns a word, so an empty expectation list means idle.
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_idle_wait(input logic [WAIT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    idle_wait_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned quiet_tail);
    for (int unsigned n = 0; n < count; n++)
      pending_cmds.push_back(random_cmd(n + quiet_tail >= count));
    drain_block();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, idle_wait at its reset value.
    pending_cmds.push_back(job_cmd(OP_POLL, 48'd1000, 0, 0, 0, 0));
    pending_cmds.push_back(job_cmd(OP_QUERY, 48'd1000, 0, 0, 0, 31'h7FFFFFFF));
    pending_cmds.push_back(job_cmd(OP_ADD, 48'd0, 8'sd127, 0, 32'hFFFFFFFF, 0));
    pending_cmds.push_back(job_cmd(OP_ADD, '1, -8'sd128, 32'hFFFFFFFF, 0, 0));
    pending_cmds.push_back(job_cmd(OP_ADD, 48'd1000, 0, 32'd500, 32'h5A5A5A5A, 0));
    pending_cmds.push_back(job_cmd(OP_POLL, 48'd1000, 0, 0, 0, 0));
    pending_cmds.push_back(job_cmd(OP_POLL, 48'd1000, 0, 0, 0, 0));
    pending_cmds.push_back(job_cmd(OP_QUERY, 48'd1000, 0, 0, 0, 31'd2));
    pending_cmds.push_back(job_cmd(OP_CANCEL, 48'd1000, 0, 0, 0, 31'd2));
    pending_cmds.push_back(job_cmd(OP_CANCEL, 48'd1000, 0, 0, 0, 31'd2));
    pending_cmds.push_back(job_cmd(OP_QUERY, 48'd1000, 0, 0, 0, 31'd2));
    // Only the saturated job is left, far beyond the horizon.
    pending_cmds.push_back(job_cmd(OP_POLL, 48'd5, 0, 0, 0, 0));
    for (int k = 5; k <= 7; k++)
      pending_cmds.push_back(job_cmd(3'(k), 48'd7, 0, 0, 0, 0));
    // Fill the table with equal keys apart from id; the last add is rejected.
    for (int k = 0; k < 16; k++)
      pending_cmds.push_back(job_cmd(OP_ADD, 48'd10, 8'sd1, 0, 32'(k), 0));
    pending_cmds.push_back(job_cmd(OP_POLL, 48'd10, 0, 0, 0, 0));
    pending_cmds.push_back(job_cmd(OP_CLEAR, 48'd10, 0, 0, 0, 0));
    drain_block();

    write_idle_wait('0);
    run_random(400, 0);
    write_idle_wait('1);
    run_random(400, 0);
    write_idle_wait(24'($urandom));
    run_random(650, 200);

    $display("Checked %0d result words: %0d dispatches, %0d empty polls, %0d full adds.",
             words_checked, polls_dispatched, polls_waiting, adds_rejected);
    $display("idle_wait was set to zero, all ones and a random value between phases.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d result words outstanding.", expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/tpjq_pkg.sv
sv/tpjq_ctrl.sv
sv/tpjq_datapath.sv
sv/timed_priority_job_queue.sv
sv/tpjq_checker.sv
tb/tb_top.sv
